### rtl/aapr_pkg.sv
// Package: word types, fixed-point constants and arctangent table for the rotation block.
`timescale 1ns / 1ps
`default_nettype none
package aapr_pkg;

  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_target_x;
    logic signed [31:0] new_target_y;
    logic signed [31:0] new_target_z;
    logic               saturated;
  } out_t;

  // Data that rides alongside the CORDIC pipe
  typedef struct packed {
    logic               neg;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [32:0] vx;
    logic signed [32:0] vy;
    logic signed [32:0] vz;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] ez;
  } side_t;

  localparam int ANG_W     = 34;
  localparam int CRD_W     = 34;
  localparam int ATAN_N    = 24;

  localparam logic signed [ANG_W-1:0] PI_Q28      = 34'sd843314857;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q28  = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = 34'sd421657428;
  localparam logic signed [CRD_W-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [CRD_W-1:0] ONE_Q30     = 34'sd1073741824;

  function automatic logic signed [ANG_W-1:0] atan_q28(input logic [4:0] idx);
    logic signed [ANG_W-1:0] r;
    unique case (idx)
      5'd0:  r = 34'sd210828714;
      5'd1:  r = 34'sd124459457;
      5'd2:  r = 34'sd65760959;
      5'd3:  r = 34'sd33381290;
      5'd4:  r = 34'sd16755422;
      5'd5:  r = 34'sd8385879;
      5'd6:  r = 34'sd4193963;
      5'd7:  r = 34'sd2097109;
      5'd8:  r = 34'sd1048571;
      5'd9:  r = 34'sd524287;
      5'd10: r = 34'sd262144;
      5'd11: r = 34'sd131072;
      5'd12: r = 34'sd65536;
      5'd13: r = 34'sd32768;
      5'd14: r = 34'sd16384;
      5'd15: r = 34'sd8192;
      5'd16: r = 34'sd4096;
      5'd17: r = 34'sd2048;
      5'd18: r = 34'sd1024;
      5'd19: r = 34'sd512;
      5'd20: r = 34'sd256;
      5'd21: r = 34'sd128;
      5'd22: r = 34'sd64;
      5'd23: r = 34'sd32;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/aapr_cordic.sv
// Unrolled rotation-mode CORDIC, one registered stage per iteration.
`timescale 1ns / 1ps
`default_nettype none
module aapr_cordic
  import aapr_pkg::*;
#(
  parameter int STAGES = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire logic signed [ANG_W-1:0] z_i,
  input  wire side_t                   side_i,
  output logic                         valid_o,
  output logic signed [CRD_W-1:0]      cos_o,
  output logic signed [CRD_W-1:0]      sin_o,
  output side_t                        side_o
);

  logic                    vld_q  [STAGES+1];
  logic signed [CRD_W-1:0] x_q    [STAGES+1];
  logic signed [CRD_W-1:0] y_q    [STAGES+1];
  logic signed [ANG_W-1:0] z_q    [STAGES+1];
  side_t                   side_q [STAGES+1];

  always_comb begin
    vld_q[0]  = valid_i;
    x_q[0]    = GAIN_Q30;
    y_q[0]    = '0;
    z_q[0]    = z_i;
    side_q[0] = side_i;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [CRD_W-1:0] xs, ys, x_d, y_d;
    logic signed [ANG_W-1:0] z_d;

    always_comb begin
      xs = x_q[i] >>> i;
      ys = y_q[i] >>> i;
      if (!z_q[i][ANG_W-1]) begin
        x_d = x_q[i] - ys;
        y_d = y_q[i] + xs;
        z_d = z_q[i] - atan_q28(5'(i));
      end else begin
        x_d = x_q[i] + ys;
        y_d = y_q[i] - xs;
        z_d = z_q[i] + atan_q28(5'(i));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]    <= x_d;
        y_q[i+1]    <= y_d;
        z_q[i+1]    <= z_d;
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign valid_o = vld_q[STAGES];
  assign cos_o   = x_q[STAGES];
  assign sin_o   = y_q[STAGES];
  assign side_o  = side_q[STAGES];

endmodule
`default_nettype wire

### rtl/axis_angle_point_rotation.sv
// Top level: axis-angle rotation of a look-at point about an eye point.
`timescale 1ns / 1ps
`default_nettype none
// Rotates target about eye: new = eye + R*(target - eye), R built from cosine and
// sine of the angle by the axis-angle formula with the axis taken as given (no
// normalising). One word is taken every cycle while the pipe is not held. The
// pipe is the unrolled CORDIC (one iteration per stage) plus the angle
// reduction, folding, matrix build and the multiply and accumulate stages. The
// whole pipe advances together; it holds while a finished word waits on out_stall_i.
// Results saturate to 32 bits and raise the saturated flag.
module axis_angle_point_rotation
  import aapr_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  logic adv;
  // Advance while the output register is empty or being drained
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // Stage 1: view vector and first angle reduction
  logic                    v1_q;
  logic signed [ANG_W-1:0] t1_q;
  side_t                   s1_q;
  logic signed [ANG_W-1:0] t0, t0r;

  always_comb begin
    t0 = $signed({{2{in_data_i.angle[15]}}, in_data_i.angle, 16'b0});
    if (t0 > PI_Q28) begin
      t0r = t0 - TWO_PI_Q28;
    end else if (t0 < -PI_Q28) begin
      t0r = t0 + TWO_PI_Q28;
    end else begin
      t0r = t0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_q    <= t0r;
      s1_q.neg <= 1'b0;
      s1_q.ax <= in_data_i.axis_x;
      s1_q.ay <= in_data_i.axis_y;
      s1_q.az <= in_data_i.axis_z;
      s1_q.vx <= 33'(in_data_i.target_x) - 33'(in_data_i.eye_x);
      s1_q.vy <= 33'(in_data_i.target_y) - 33'(in_data_i.eye_y);
      s1_q.vz <= 33'(in_data_i.target_z) - 33'(in_data_i.eye_z);
      s1_q.ex <= in_data_i.eye_x;
      s1_q.ey <= in_data_i.eye_y;
      s1_q.ez <= in_data_i.eye_z;
    end
  end

  // Stage 2: fold into the right half plane
  logic                    v2_q;
  logic signed [ANG_W-1:0] t2_q;
  side_t                   s2_q;
  logic signed [ANG_W-1:0] t1f;
  side_t                   s1f;

  always_comb begin
    s1f = s1_q;
    if (t1_q > HALF_PI_Q28) begin
      t1f     = t1_q - PI_Q28;
      s1f.neg = 1'b1;
    end else if (t1_q < -HALF_PI_Q28) begin
      t1f     = t1_q + PI_Q28;
      s1f.neg = 1'b1;
    end else begin
      t1f     = t1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t2_q <= t1f;
      s2_q <= s1f;
    end
  end

  logic                    vc;
  logic signed [CRD_W-1:0] cx, cy;
  side_t                   sc;

  aapr_cordic #(
    .STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(v2_q),
    .z_i    (t2_q),
    .side_i (s2_q),
    .valid_o(vc),
    .cos_o  (cx),
    .sin_o  (cy),
    .side_o (sc)
  );

  // Stage 3: sign fix, one minus cosine, axis products
  logic                    v3_q;
  logic signed [CRD_W-1:0] omc3_q, sin3_q;
  logic signed [27:0]      c24_3_q;
  logic signed [31:0]      aa3_q [6];
  side_t                   s3_q;
  logic signed [CRD_W-1:0] cf, sf;

  assign cf = sc.neg ? -cx : cx;
  assign sf = sc.neg ? -cy : cy;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      omc3_q   <= ONE_Q30 - cf;
      sin3_q   <= sf;
      c24_3_q  <= 28'(cf >>> 6);
      aa3_q[0] <= sc.ax * sc.ax;
      aa3_q[1] <= sc.ax * sc.ay;
      aa3_q[2] <= sc.ax * sc.az;
      aa3_q[3] <= sc.ay * sc.ay;
      aa3_q[4] <= sc.ay * sc.az;
      aa3_q[5] <= sc.az * sc.az;
      s3_q     <= sc;
    end
  end

  // Stage 4: outer products and skew terms
  logic                    v4_q;
  logic signed [29:0]      o4_q [6];
  logic signed [27:0]      sk4_q [3];
  logic signed [27:0]      c24_4_q;
  side_t                   s4_q;
  logic signed [65:0]      op [6];
  logic signed [49:0]      sp [3];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      op[k] = omc3_q * aa3_q[k];
    end
    sp[0] = s3_q.ax * sin3_q;
    sp[1] = s3_q.ay * sin3_q;
    sp[2] = s3_q.az * sin3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        o4_q[k] <= 30'(op[k] >>> 34);
      end
      for (int k = 0; k < 3; k++) begin
        sk4_q[k] <= 28'(sp[k] >>> 20);
      end
      c24_4_q <= c24_3_q;
      s4_q    <= s3_q;
    end
  end

  // Stage 5: matrix entries, row major
  logic               v5_q;
  logic signed [29:0] m5_q [9];
  side_t              s5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m5_q[0] <= 30'(c24_4_q) + o4_q[0];
      m5_q[1] <= o4_q[1] - 30'(sk4_q[2]);
      m5_q[2] <= o4_q[2] + 30'(sk4_q[1]);
      m5_q[3] <= o4_q[1] + 30'(sk4_q[2]);
      m5_q[4] <= 30'(c24_4_q) + o4_q[3];
      m5_q[5] <= o4_q[4] - 30'(sk4_q[0]);
      m5_q[6] <= o4_q[2] - 30'(sk4_q[1]);
      m5_q[7] <= o4_q[4] + 30'(sk4_q[0]);
      m5_q[8] <= 30'(c24_4_q) + o4_q[5];
      s5_q    <= s4_q;
    end
  end

  // Stage 6: nine entry-by-vector products
  logic               v6_q;
  logic signed [62:0] p6_q [9];
  side_t              s6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        p6_q[3*r]   <= m5_q[3*r]   * s5_q.vx;
        p6_q[3*r+1] <= m5_q[3*r+1] * s5_q.vy;
        p6_q[3*r+2] <= m5_q[3*r+2] * s5_q.vz;
      end
      s6_q <= s5_q;
    end
  end

  // Stage 7: row sums
  logic               v7_q;
  logic signed [63:0] acc7_q [3];
  side_t              s7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        acc7_q[r] <= 64'(p6_q[3*r]) + 64'(p6_q[3*r+1]) + 64'(p6_q[3*r+2]);
      end
      s7_q <= s6_q;
    end
  end

  // Output stage: back to coordinate format, add eye, clamp
  logic signed [40:0] res [3];
  logic signed [31:0] sat [3];
  logic [2:0]         clp;
  out_t               out_q;

  always_comb begin
    res[0] = 41'(acc7_q[0] >>> 24) + 41'(s7_q.ex);
    res[1] = 41'(acc7_q[1] >>> 24) + 41'(s7_q.ey);
    res[2] = 41'(acc7_q[2] >>> 24) + 41'(s7_q.ez);
    for (int r = 0; r < 3; r++) begin
      if (res[r] > 41'sd2147483647) begin
        sat[r] = 32'sh7fffffff;
        clp[r] = 1'b1;
      end else if (res[r] < -41'sd2147483648) begin
        sat[r] = 32'sh80000000;
        clp[r] = 1'b1;
      end else begin
        sat[r] = 32'(res[r]);
        clp[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.new_target_x <= sat[0];
      out_q.new_target_y <= sat[1];
      out_q.new_target_z <= sat[2];
      out_q.saturated    <= |clp;
    end
  end

  // Valid bits travel with the data
  logic vo_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= vc;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      vo_q <= v7_q;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

### tb/axis_angle_point_rotation_test.sv
// Testbench: random and directed axis-angle rotations checked against a bit-exact predictor.
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard for rotated points: note each accepted word, check each result word.
class rotation_board;
  aapr_pkg::out_t pending_q[$];
  int mismatches;

  // Floor division by a power of two.
  static function longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // Compute cosine and sine of the angle, both Q.30.
  static function void cordic_sin_cos(input longint ang, output longint c, output longint s);
    longint t, x, y, xs, ys;
    bit neg;
    logic signed [33:0] at;
    t = ang * 65536;
    neg = 0;
    x = aapr_pkg::GAIN_Q30;
    y = 0;
    if (t > aapr_pkg::PI_Q28) t -= aapr_pkg::TWO_PI_Q28;
    else if (t < -aapr_pkg::PI_Q28) t += aapr_pkg::TWO_PI_Q28;
    if (t > aapr_pkg::HALF_PI_Q28) begin
      t -= aapr_pkg::PI_Q28;
      neg = 1;
    end else if (t < -aapr_pkg::HALF_PI_Q28) begin
      t += aapr_pkg::PI_Q28;
      neg = 1;
    end
    for (int i = 0; i < 16 && i < aapr_pkg::ATAN_N; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      case (i)
        0: at = 210828714;  1: at = 124459457;  2: at = 65760959;  3: at = 33381290;
        4: at = 16755422;   5: at = 8385879;    6: at = 4193963;   7: at = 2097109;
        8: at = 1048571;    9: at = 524287;     10: at = 262144;   11: at = 131072;
        12: at = 65536;     13: at = 32768;     14: at = 16384;    default: at = 8192;
      endcase
      if (t >= 0) begin
        x -= ys; y += xs; t -= at;
      end else begin
        x += ys; y -= xs; t += at;
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function void note_word(aapr_pkg::in_t w);
    longint c, s, omc, c24, a[3], v[3], e[3], sa[3], m[3][3], acc, res;
    aapr_pkg::out_t r;
    a[0] = w.axis_x; a[1] = w.axis_y; a[2] = w.axis_z;
    e[0] = w.eye_x; e[1] = w.eye_y; e[2] = w.eye_z;
    v[0] = longint'(w.target_x) - e[0];
    v[1] = longint'(w.target_y) - e[1];
    v[2] = longint'(w.target_z) - e[2];
    cordic_sin_cos(longint'(w.angle), c, s);
    omc = (64'sd1 <<< 30) - c;
    c24 = c >>> 6;
    for (int k = 0; k < 3; k++) sa[k] = (a[k] * s) >>> 20;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i][j] = (omc * (a[i] * a[j])) >>> 34;
    for (int i = 0; i < 3; i++) m[i][i] += c24;
    m[0][1] -= sa[2]; m[1][0] += sa[2];
    m[0][2] += sa[1]; m[2][0] -= sa[1];
    m[1][2] -= sa[0]; m[2][1] += sa[0];
    r = '0;
    for (int i = 0; i < 3; i++) begin
      acc = m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2];
      res = (acc >>> 24) + e[i];
      // Clamp to 32 bits and raise the flag
      if (res > 64'sd2147483647) begin
        res = 64'sd2147483647; r.saturated = 1;
      end else if (res < -64'sd2147483648) begin
        res = -64'sd2147483648; r.saturated = 1;
      end
      case (i)
        0: r.new_target_x = res[31:0];
        1: r.new_target_y = res[31:0];
        default: r.new_target_z = res[31:0];
      endcase
    end
    pending_q.push_back(r);
  endfunction

  function void check_word(aapr_pkg::out_t got);
    aapr_pkg::out_t want;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word %h", got);
      return;
    end
    want = pending_q.pop_front();
    if (got.new_target_x !== want.new_target_x || got.new_target_y !== want.new_target_y ||
        got.new_target_z !== want.new_target_z || got.saturated !== want.saturated) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected x=%0d y=%0d z=%0d sat=%0b, got x=%0d y=%0d z=%0d sat=%0b",
                 want.new_target_x, want.new_target_y, want.new_target_z, want.saturated,
                 got.new_target_x, got.new_target_y, got.new_target_z, got.saturated);
    end
  endfunction
endclass

module axis_angle_point_rotation_test;
  import aapr_pkg::*;

  localparam int LATENCY = 16 + 8;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  out_t out_data_o;

  rotation_board board = new();
  int accepted;

  axis_angle_point_rotation dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // Note each accepted input word and check each accepted result word at the edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      board.note_word(in_data_i);
      accepted++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) board.check_word(out_data_o);
  end

  // Receiver stalls in its own pattern: quiet stretches, then random stalls.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 0;
    end else if ((accepted / 150) % 3 == 1) begin
      out_stall_i <= 0;
    end else begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 2000) - 1000;
      3: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'h4000;
      1: return 16'hc000;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 32767)) - 16'sd16384;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one word and hold it until the block takes it.
  task automatic send_word(in_t w);
    in_valid_i <= 1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      in_valid_i <= 0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic in_t make_word(logic [15:0] ang, logic [15:0] ax, logic [15:0] ay,
                                    logic [15:0] az, logic [31:0] tx, logic [31:0] ty,
                                    logic [31:0] tz, logic [31:0] ex, logic [31:0] ey,
                                    logic [31:0] ez);
    return '{ang, ax, ay, az, tx, ty, tz, ex, ey, ez};
  endfunction

  function automatic in_t random_word();
    logic [15:0] ang;
    case ($urandom_range(0, 3))
      0: ang = 16'($urandom_range(0, 25736)) - 16'sd12868;
      default: ang = 16'($urandom);
    endcase
    return make_word(ang, rand_axis(), rand_axis(), rand_axis(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endfunction

  initial begin
    int burst;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: angle extremes, reduction and folding edges, unit, zero and oversize axes,
    // coordinate extremes that force clamping in both directions.
    send_word(make_word(16'h0000, 16'h4000, 0, 0, 32'h10000, 32'h20000, 32'h30000, 0, 0, 0));
    send_word(make_word(16'h7fff, 0, 0, 16'h4000, 32'h10000, 0, 0, 0, 0, 0));
    send_word(make_word(16'h8000, 0, 16'h4000, 0, 32'h10000, 32'h5000, 0, 0, 0, 0));
    send_word(make_word(16'd12868, 0, 0, 16'h4000, 32'h10000, 0, 0, 32'h100, 0, 0));
    send_word(make_word(-16'sd12868, 0, 0, 16'h4000, 32'h10000, 0, 0, 0, 0, 0));
    send_word(make_word(16'd12869, 16'h4000, 0, 0, 0, 32'h10000, 0, 0, 0, 0));
    send_word(make_word(16'd6434, 0, 0, 16'h4000, 32'h10000, 0, 0, 0, 0, 0));
    send_word(make_word(-16'sd6434, 0, 0, 16'h4000, 32'h10000, 0, 0, 0, 0, 0));
    send_word(make_word(16'd6435, 0, 16'h4000, 0, 0, 0, 32'h10000, 0, 0, 0));
    send_word(make_word(16'd25736, 0, 0, 16'hc000, 32'h10000, 0, 0, 0, 0, 0));
    send_word(make_word(16'd3000, 0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 0, 0, 0));
    send_word(make_word(16'd3000, 16'h7fff, 16'h7fff, 16'h7fff, 32'h1000, 0, 0, 0, 0, 0));
    send_word(make_word(16'd3000, 16'h8000, 16'h8000, 16'h8000, 0, 32'h1000, 0, 0, 0, 0));
    send_word(make_word(16'h0000, 16'h4000, 0, 0, 32'h7fffffff, 0, 0, 32'h80000000, 0, 0));
    send_word(make_word(16'd12868, 0, 0, 16'h4000, 32'h7fffffff, 0, 0, 32'h80000000, 0, 0));
    send_word(make_word(16'd6434, 16'h7fff, 16'h8000, 16'h7fff, 32'h7fffffff, 32'h80000000,
                        32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000));
    send_word(make_word(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 32'h80000000, 32'h7fffffff,
                        32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
    send_word(make_word(16'hffff, 16'hffff, 16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff,
                        32'hffffffff, 32'h0, 32'h0, 32'h0));
    idle_cycles(1);

    // Pause until every expected result has come.
    while (board.pending_q.size() != 0) @(posedge clk_i);

    // Random: bursts of back-to-back words separated by random gaps.
    for (int n = 0; n < 1000; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) send_word(random_word());
      n += burst;
      idle_cycles(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
    end
    in_valid_i <= 0;

    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_q.size() == 0) begin
      $display("axis_angle_point_rotation_test: PASS");
    end else begin
      $display("axis_angle_point_rotation_test: FAIL");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #2000000;
    $display("axis_angle_point_rotation_test: FAIL");
    $finish;
  end
endmodule

`default_nettype wire
